FILE: rtl/core/mahd_pkg.sv
`default_nettype none

package mahd_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    // version codes as reported
    localparam logic [1:0] VER_MPEG1    = 2'd0;
    localparam logic [1:0] VER_MPEG2    = 2'd1;
    localparam logic [1:0] VER_MPEG25   = 2'd2;
    localparam logic [1:0] VER_RESERVED = 2'd3;

    // layer codes as reported
    localparam logic [1:0] LAYER_RES = 2'd0;
    localparam logic [1:0] LAYER_1   = 2'd1;
    localparam logic [1:0] LAYER_2   = 2'd2;
    localparam logic [1:0] LAYER_3   = 2'd3;

    localparam logic [1:0] SR_RESERVED = 2'd3;
    localparam logic [3:0] BR_BAD      = 4'hF;

    localparam logic [10:0] SPF_L1   = 11'd384;
    localparam logic [10:0] SPF_FULL = 11'd1152;
    localparam logic [10:0] SPF_LSF3 = 11'd576;

    localparam logic [7:0] COEF_L1   = 8'd12;
    localparam logic [7:0] COEF_LSF3 = 8'd72;
    localparam logic [7:0] COEF_STD  = 8'd144;
    localparam logic [3:0] DEC_SCALE = 4'd10;

    localparam logic [15:0] RATE_44K1 = 16'd44100;
    localparam logic [15:0] RATE_48K  = 16'd48000;
    localparam logic [15:0] RATE_32K  = 16'd32000;

    // kbps*1000/rate reduced per base rate: 10/441, 1/48, 1/32
    localparam int          DIV_SHIFT = 20;
    localparam logic [8:0]  DIV_44K1  = 9'd441;
    localparam logic [8:0]  DIV_48K   = 9'd48;
    localparam logic [8:0]  DIV_32K   = 9'd32;
    localparam logic [15:0] RCP_44K1  = 16'd2377;
    localparam logic [15:0] RCP_48K   = 16'd21845;
    localparam logic [15:0] RCP_32K   = 16'd32768;

    localparam logic [11:0] MAX_QUOT  = 12'd2880;
    localparam logic [13:0] HDR_BYTES = 14'd4;

    typedef logic [14:0][8:0] kbps_row_t;

    // entries listed from index 14 down to index 0
    localparam kbps_row_t KBPS_M1_L1 = {9'd448, 9'd416, 9'd384, 9'd352, 9'd320, 9'd288,
        9'd256, 9'd224, 9'd192, 9'd160, 9'd128, 9'd96, 9'd64, 9'd32, 9'd0};
    localparam kbps_row_t KBPS_M1_L2 = {9'd384, 9'd320, 9'd256, 9'd224, 9'd192, 9'd160,
        9'd128, 9'd112, 9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd32, 9'd0};
    localparam kbps_row_t KBPS_M1_L3 = {9'd320, 9'd256, 9'd224, 9'd192, 9'd160, 9'd128,
        9'd112, 9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd40, 9'd32, 9'd0};
    localparam kbps_row_t KBPS_LSF_L1 = {9'd256, 9'd224, 9'd192, 9'd176, 9'd160, 9'd144,
        9'd128, 9'd112, 9'd96, 9'd80, 9'd64, 9'd56, 9'd48, 9'd32, 9'd0};
    localparam kbps_row_t KBPS_LSF_L23 = {9'd160, 9'd144, 9'd128, 9'd112, 9'd96, 9'd80,
        9'd64, 9'd56, 9'd48, 9'd40, 9'd32, 9'd24, 9'd16, 9'd8, 9'd0};

    typedef enum logic [1:0] {
        BASE_44K1 = 2'd0,
        BASE_48K  = 2'd1,
        BASE_32K  = 2'd2
    } base_t;

    typedef struct packed {
        logic        valid_res;
        logic [1:0]  version;
        logic [1:0]  layer;
        logic        crc_present;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic        padding;
        logic [2:0]  misc_flags;
        logic [1:0]  channel_mode;
        logic [1:0]  emphasis;
        logic [10:0] samples_per_frame;
    } hdr_t;

    // one classified header on its way to the length unit
    typedef struct packed {
        hdr_t        hdr;
        logic        div_en;
        logic        len_x4;
        base_t       base;
        logic [19:0] num;
    } rec_t;

    typedef struct packed {
        hdr_t        hdr;
        logic [11:0] payload_bytes;
    } res_t;

    function automatic base_t base_of(input logic [1:0] sr_idx);
        base_t b;
        unique case (sr_idx)
            2'd0:    b = BASE_44K1;
            2'd1:    b = BASE_48K;
            default: b = BASE_32K;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sr_idx);
        logic [15:0] r;
        unique case (base_of(sr_idx))
            BASE_44K1: r = RATE_44K1;
            BASE_48K:  r = RATE_48K;
            default:   r = RATE_32K;
        endcase
        if (ver == VER_RESERVED || sr_idx == SR_RESERVED)
        begin
            r = 16'd0;
        end
        return r >> ver;
    endfunction

    function automatic logic [8:0] kbps_lookup(input logic [2:0] row, input logic [3:0] idx);
        logic [8:0] k;
        unique case (row)
            3'd0:    k = KBPS_M1_L1[idx];
            3'd1:    k = KBPS_M1_L2[idx];
            3'd2:    k = KBPS_M1_L3[idx];
            3'd3:    k = KBPS_LSF_L1[idx];
            default: k = KBPS_LSF_L23[idx];
        endcase
        return k;
    endfunction

    function automatic logic [10:0] coef_scaled(input logic l1, input logic lsf3,
                                                input base_t base);
        logic [7:0] c;
        c = l1 ? COEF_L1 : (lsf3 ? COEF_LSF3 : COEF_STD);
        return (base == BASE_44K1) ? 11'(c) * 11'(DEC_SCALE) : 11'(c);
    endfunction

    function automatic logic [8:0] div_of(input base_t base);
        logic [8:0] d;
        unique case (base)
            BASE_44K1: d = DIV_44K1;
            BASE_48K:  d = DIV_48K;
            default:   d = DIV_32K;
        endcase
        return d;
    endfunction

    function automatic logic [15:0] rcp_of(input base_t base);
        logic [15:0] r;
        unique case (base)
            BASE_44K1: r = RCP_44K1;
            BASE_48K:  r = RCP_48K;
            default:   r = RCP_32K;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/mahd_front.sv
`default_nettype none

module mahd_front (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [31:0]        header,
    output logic               out_valid,
    input  wire                out_ready,
    output mahd_pkg::rec_t     out_rec
);
    import mahd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    rec_t        rec_reg;
    rec_t        rec_next;

    logic [1:0]  vbits;
    logic [1:0]  lbits;
    logic [3:0]  br_idx;
    logic [1:0]  sr_idx;
    logic [1:0]  ver;
    logic [1:0]  lay;
    logic [2:0]  row;
    logic        row_ok;
    logic        br_ok;
    logic [15:0] rate;
    logic [8:0]  kbps;
    logic        valid_hdr;
    logic        lsf3;
    base_t       base;
    logic [12:0] coef_x;
    logic [21:0] prod;
    logic [10:0] spf;

    assign vbits  = header[20:19];
    assign lbits  = header[18:17];
    assign br_idx = header[15:12];
    assign sr_idx = header[11:10];

    always_comb
    begin
        unique case (vbits)
            2'd3:    ver = VER_MPEG1;
            2'd2:    ver = VER_MPEG2;
            2'd0:    ver = VER_MPEG25;
            default: ver = VER_RESERVED;
        endcase
        lay = (lbits == 2'd0) ? LAYER_RES : 2'(3'd4 - {1'b0, lbits});

        row_ok = (lay != LAYER_RES) && (ver != VER_RESERVED);
        if (ver == VER_MPEG1)
        begin
            row = 3'({1'b0, lay} - 3'd1);
        end
        else
        begin
            row = (lay == LAYER_1) ? 3'd3 : 3'd4;
        end
        br_ok = row_ok && (br_idx != BR_BAD);
        kbps  = br_ok ? kbps_lookup(row, br_idx) : 9'd0;
        rate  = rate_lookup(ver, sr_idx);
        valid_hdr = br_ok && (rate != 16'd0);

        unique case (lay)
            LAYER_1: spf = SPF_L1;
            LAYER_2: spf = SPF_FULL;
            LAYER_3: spf = (ver == VER_MPEG1) ? SPF_FULL :
                           (ver == VER_RESERVED) ? 11'd0 : SPF_LSF3;
            default: spf = 11'd0;
        endcase

        lsf3   = (lay == LAYER_3) && (ver != VER_MPEG1);
        base   = base_of(sr_idx);
        // lower sampling rates are the base rate over 2^version
        coef_x = 13'(coef_scaled(lay == LAYER_1, lsf3, base)) << ver;
        prod   = coef_x * kbps;
    end

    always_comb
    begin
        rec_next                        = rec_reg;
        rec_next.hdr.valid_res          = valid_hdr;
        rec_next.hdr.version            = ver;
        rec_next.hdr.layer              = lay;
        rec_next.hdr.crc_present        = ~header[16];
        rec_next.hdr.bitrate_kbps       = kbps;
        rec_next.hdr.sample_rate_hz     = rate;
        rec_next.hdr.padding            = header[9];
        rec_next.hdr.misc_flags         = {header[8], header[3], header[2]};
        rec_next.hdr.channel_mode       = header[7:6];
        rec_next.hdr.emphasis           = header[1:0];
        rec_next.hdr.samples_per_frame  = spf;
        rec_next.div_en                 = valid_hdr && (kbps != 9'd0);
        rec_next.len_x4                 = (lay == LAYER_1);
        rec_next.base                   = base;
        rec_next.num                    = prod[19:0];
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rec_reg <= rec_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_rec   = rec_reg;

endmodule

`default_nettype wire

FILE: rtl/core/mahd_queue.sv
`default_nettype none

module mahd_queue #(
    parameter int DEPTH = mahd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  mahd_pkg::rec_t     in_rec,
    output logic               out_valid,
    input  wire                out_ready,
    output mahd_pkg::rec_t     out_rec
);
    import mahd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    rec_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != FULL);
    assign out_valid = (count_reg != '0);
    assign out_rec   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : AW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : AW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            count_next = CW'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_rec;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/mahd_back.sv
`default_nettype none

module mahd_back (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  mahd_pkg::rec_t     in_rec,
    output logic               out_valid,
    input  wire                out_ready,
    output mahd_pkg::res_t     out_res
);
    import mahd_pkg::*;

    // stage 1: reciprocal estimate, stage 2: remainder fix-up, stage 3: length
    logic        v1_reg;
    logic        v1_next;
    logic        v2_reg;
    logic        v2_next;
    logic        v3_reg;
    logic        v3_next;
    logic        rdy1;
    logic        rdy2;
    logic        rdy3;

    rec_t        s1_rec_reg;
    logic [11:0] s1_q_reg;
    rec_t        s2_rec_reg;
    logic [11:0] s2_q_reg;
    res_t        s3_res_reg;
    res_t        s3_res_next;

    logic [35:0] est_prod;
    logic [8:0]  s2_div;
    logic [20:0] s2_back;
    logic [19:0] s2_rem;
    logic [11:0] s2_q_next;
    logic [12:0] s3_sum;
    logic [13:0] s3_len;

    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    assign v1_next = rdy1 ? in_valid : v1_reg;
    assign v2_next = rdy2 ? v1_reg : v2_reg;
    assign v3_next = rdy3 ? v2_reg : v3_reg;

    // estimate is the true quotient or one short of it
    assign est_prod = in_rec.num * rcp_of(in_rec.base);

    assign s2_div    = div_of(s1_rec_reg.base);
    assign s2_back   = s1_q_reg * s2_div;
    assign s2_rem    = s1_rec_reg.num - s2_back[19:0];
    assign s2_q_next = (s2_rem >= 20'(s2_div)) ? 12'(s1_q_reg + 1'b1) : s1_q_reg;

    always_comb
    begin
        s3_sum = 13'(s2_q_reg) + 13'(s2_rec_reg.hdr.padding);
        s3_len = s2_rec_reg.len_x4 ? {s3_sum, 1'b0} << 1 : 14'(s3_sum);
        s3_res_next.hdr = s2_rec_reg.hdr;
        if (s2_rec_reg.div_en && s3_len >= HDR_BYTES)
        begin
            s3_res_next.payload_bytes = 12'(s3_len - HDR_BYTES);
        end
        else
        begin
            s3_res_next.payload_bytes = 12'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            s1_rec_reg <= in_rec;
            s1_q_reg   <= est_prod[DIV_SHIFT+11:DIV_SHIFT];
        end
        if (v1_reg && rdy2)
        begin
            s2_rec_reg <= s1_rec_reg;
            s2_q_reg   <= s2_q_next;
        end
        if (v2_reg && rdy3)
        begin
            s3_res_reg <= s3_res_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_res   = s3_res_reg;

    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg && s1_rec_reg.div_en |-> s2_rem < {11'd0, s2_div, 1'b0})
        else $error("quotient estimate more than one short");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && s2_rec_reg.div_en |-> s2_q_reg <= MAX_QUOT)
        else $error("frame length quotient out of range");

    a_invalid_len: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !s3_res_reg.hdr.valid_res |-> s3_res_reg.payload_bytes == 12'd0)
        else $error("length reported for invalid header");

    a_free_len: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && s3_res_reg.hdr.bitrate_kbps == 9'd0 |-> s3_res_reg.payload_bytes == 12'd0)
        else $error("length reported for free format");

endmodule

`default_nettype wire

FILE: rtl/core/mpeg_audio_header_decoder.sv
// An accepted header word passes the front register, a queue slot and three length
// stages on its way to its result word.
// Throughput: one header per cycle while the output does not stall; the length
// unit is a 3-stage reciprocal-multiply pipeline shared by all nine sampling rates.
// Front decode and back length unit are parted by a small queue and stall on their own.
// Reset (rst_n low, asynchronous) empties the pipeline and the queue; no result is pending.
`default_nettype none

module mpeg_audio_header_decoder #(
    parameter int QUEUE_DEPTH = mahd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // header_word
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // valid_res, version, layer, crc_present, bitrate_kbps, sample_rate_hz, padding,
    // misc_flags, channel_mode, emphasis, samples_per_frame, payload_bytes, zero fill
    output logic [63:0] m_axis_tdata
);
    import mahd_pkg::*;

    logic  fr_valid;
    logic  fr_ready;
    rec_t  fr_rec;
    logic  q_valid;
    logic  q_ready;
    rec_t  q_rec;
    res_t  res;

    mahd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .header    (s_axis_tdata),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_rec   (fr_rec)
    );

    mahd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_rec    (fr_rec),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_rec   (q_rec)
    );

    mahd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_rec    (q_rec),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    assign m_axis_tdata = {
        2'b00,
        res.payload_bytes,
        res.hdr.samples_per_frame,
        res.hdr.emphasis,
        res.hdr.channel_mode,
        res.hdr.misc_flags,
        res.hdr.padding,
        res.hdr.sample_rate_hz,
        res.hdr.bitrate_kbps,
        res.hdr.crc_present,
        res.hdr.layer,
        res.hdr.version,
        res.hdr.valid_res
    };

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

    import mahd_pkg::*;

    // version and layer bit codes as they sit in the header
    localparam logic [1:0] HV_MPEG25 = 2'b00;
    localparam logic [1:0] HV_RES    = 2'b01;
    localparam logic [1:0] HV_MPEG2  = 2'b10;
    localparam logic [1:0] HV_MPEG1  = 2'b11;
    localparam logic [1:0] HL_RES    = 2'b00;
    localparam logic [1:0] HL_3      = 2'b01;
    localparam logic [1:0] HL_2      = 2'b10;
    localparam logic [1:0] HL_1      = 2'b11;

    localparam int ROW_M1_L1   = 0;
    localparam int ROW_LSF_L1  = 3;
    localparam int ROW_LSF_L23 = 4;

    localparam int RANDOM_HEADERS = 1350;
    localparam int IDLE_PCT       = 38;
    localparam int STEADY_FROM    = 600;
    localparam int STEADY_TO      = 800;
    localparam int TAIL_CYCLES    = 12;
    localparam int CYCLE_LIMIT    = 200000;

    // bitrate tables, kbit/s, index 0 leftmost
    localparam logic [0:4][0:14][8:0] KBPS_TAB = {
        9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448,
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384,
        9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320,
        9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256,
        9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160
    };

    typedef struct packed {
        logic        valid_res;
        logic [1:0]  version;
        logic [1:0]  layer;
        logic        crc_present;
        logic [8:0]  bitrate_kbps;
        logic [15:0] sample_rate_hz;
        logic        padding;
        logic [2:0]  misc_flags;
        logic [1:0]  channel_mode;
        logic [1:0]  emphasis;
        logic [10:0] samples_per_frame;
        logic [11:0] payload_bytes;
    } frame_info_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [31:0] s_axis_tdata = 32'd0;
    logic        m_axis_tready = 1'b0;
    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [63:0] m_axis_tdata;

    logic [31:0] header_q[$];
    frame_info_t frame_info_q[$];
    frame_info_t info_head;
    int          sent_cnt = 0;
    int          fail_cnt = 0;
    int          cycle_cnt = 0;
    logic        steady;

    mpeg_audio_header_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    assign steady = (sent_cnt >= STEADY_FROM) && (sent_cnt < STEADY_TO);

    function automatic frame_info_t decode_header(input logic [31:0] h);
        frame_info_t d;
        logic [1:0]  sr;
        logic [3:0]  br;
        int unsigned rate;
        int unsigned kbps;
        int unsigned bps;
        int unsigned frame_len;
        int          row;
        logic        br_ok;
        sr = h[11:10];
        br = h[15:12];
        rate = 0;
        kbps = 0;
        frame_len = 0;
        row = -1;
        br_ok = 1'b0;
        case (h[20:19])
            HV_MPEG1: d.version = VER_MPEG1;
            HV_MPEG2: d.version = VER_MPEG2;
            HV_MPEG25: d.version = VER_MPEG25;
            default: d.version = VER_RESERVED;
        endcase
        case (h[18:17])
            HL_1: d.layer = LAYER_1;
            HL_2: d.layer = LAYER_2;
            HL_3: d.layer = LAYER_3;
            default: d.layer = LAYER_RES;
        endcase
        if (d.version != VER_RESERVED && sr != SR_RESERVED)
        begin
            case (sr)
                2'd0: rate = 44100;
                2'd1: rate = 48000;
                default: rate = 32000;
            endcase
            rate = rate >> d.version;
        end
        if (d.layer != LAYER_RES)
        begin
            if (d.version == VER_MPEG1)
                row = ROW_M1_L1 + int'(d.layer) - 1;
            else if (d.version != VER_RESERVED)
                row = (d.layer == LAYER_1) ? ROW_LSF_L1 : ROW_LSF_L23;
        end
        if (row >= 0 && br != BR_BAD)
        begin
            kbps = KBPS_TAB[row][br];
            br_ok = 1'b1;
        end
        d.valid_res = (rate != 0) && br_ok;
        case (d.layer)
            LAYER_1: d.samples_per_frame = 11'd384;
            LAYER_2: d.samples_per_frame = 11'd1152;
            LAYER_3:
            begin
                if (d.version == VER_MPEG1)
                    d.samples_per_frame = 11'd1152;
                else if (d.version == VER_RESERVED)
                    d.samples_per_frame = 11'd0;
                else
                    d.samples_per_frame = 11'd576;
            end
            default: d.samples_per_frame = 11'd0;
        endcase
        if (d.valid_res && kbps != 0)
        begin
            bps = kbps * 1000;
            if (d.layer == LAYER_1)
                frame_len = (12 * bps / rate + h[9]) * 4;
            else if (d.layer == LAYER_3 && d.version != VER_MPEG1)
                frame_len = 72 * bps / rate + h[9];
            else
                frame_len = 144 * bps / rate + h[9];
            frame_len = (frame_len >= 4) ? frame_len - 4 : 0;
        end
        d.crc_present = ~h[16];
        d.bitrate_kbps = 9'(kbps);
        d.sample_rate_hz = 16'(rate);
        d.padding = h[9];
        d.misc_flags = {h[8], h[3], h[2]};
        d.channel_mode = h[7:6];
        d.emphasis = h[1:0];
        d.payload_bytes = 12'(frame_len);
        return d;
    endfunction

    function automatic logic [31:0] build_header(input logic [1:0] vb, input logic [1:0] lb,
                                                 input logic [3:0] br, input logic [1:0] sr,
                                                 input logic pad, input logic [8:0] low);
        return {11'h7FF, vb, lb, 1'b1, br, sr, pad, low};
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endtask

    // result word, lowest bit up: valid_res, version, layer, crc_present, bitrate_kbps,
    // sample_rate_hz, padding, misc_flags, channel_mode, emphasis, samples_per_frame,
    // payload_bytes
    task automatic compare_word(input frame_info_t want, input logic [63:0] w);
        check_field("valid_res", want.valid_res, w[0]);
        check_field("version", want.version, w[2:1]);
        check_field("layer", want.layer, w[4:3]);
        check_field("crc_present", want.crc_present, w[5]);
        check_field("bitrate_kbps", want.bitrate_kbps, w[14:6]);
        check_field("sample_rate_hz", want.sample_rate_hz, w[30:15]);
        check_field("padding", want.padding, w[31]);
        check_field("misc_flags", want.misc_flags, w[34:32]);
        check_field("channel_mode", want.channel_mode, w[36:35]);
        check_field("emphasis", want.emphasis, w[38:37]);
        check_field("samples_per_frame", want.samples_per_frame, w[49:39]);
        check_field("payload_bytes", want.payload_bytes, w[61:50]);
    endtask

    // header driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                frame_info_q.push_back(decode_header(s_axis_tdata));
                sent_cnt <= sent_cnt + 1;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (header_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    s_axis_tdata <= header_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (frame_info_q.size() == 0)
            begin
                $error("result word %h with no header outstanding", m_axis_tdata);
                fail_cnt++;
            end
            else
            begin
                info_head = frame_info_q.pop_front();
                compare_word(info_head, m_axis_tdata);
            end
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] h;
        int          v;
        int          l;
        logic [1:0]  ver_bits[3];
        ver_bits[0] = HV_MPEG1;
        ver_bits[1] = HV_MPEG2;
        ver_bits[2] = HV_MPEG25;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        header_q.push_back(32'h0000_0000);
        header_q.push_back(32'hFFFF_FFFF);
        // every version code against every layer code
        for (v = 0; v < 4; v++)
            for (l = 0; l < 4; l++)
                header_q.push_back(build_header(2'(v), 2'(l), 4'(1 + 3 * l + v),
                                                2'((v + l) % 3), 1'(l), 9'(v * 97 + l * 31)));
        // free format, bitrate index fifteen, reserved rate
        header_q.push_back(build_header(HV_MPEG1, HL_3, 4'd0, 2'd1, 1'b1, 9'h1FF));
        header_q.push_back(build_header(HV_MPEG1, HL_2, BR_BAD, 2'd0, 1'b0, 9'h0));
        header_q.push_back(build_header(HV_MPEG2, HL_3, 4'd9, SR_RESERVED, 1'b1, 9'h0AA));
        // longest frames and the shortest
        header_q.push_back(build_header(HV_MPEG25, HL_2, 4'd14, 2'd2, 1'b1, 9'h155));
        header_q.push_back(build_header(HV_MPEG1, HL_1, 4'd14, 2'd2, 1'b1, 9'h0F0));
        header_q.push_back(build_header(HV_MPEG1, HL_2, 4'd14, 2'd2, 1'b1, 9'h00F));
        header_q.push_back(build_header(HV_MPEG25, HL_3, 4'd1, 2'd1, 1'b0, 9'h100));

        // let the directed words drain completely before the random part
        while (header_q.size() != 0 || s_axis_tvalid || frame_info_q.size() != 0)
            @(posedge clk);

        for (v = 0; v < RANDOM_HEADERS; v++)
        begin
            h = $urandom();
            if ($urandom_range(99) < 75)
            begin
                h[31:21] = 11'h7FF;
                h[20:19] = ver_bits[$urandom_range(2)];
                h[18:17] = 2'($urandom_range(3, 1));
                h[15:12] = 4'($urandom_range(14));
                h[11:10] = 2'($urandom_range(2));
            end
            header_q.push_back(h);
        end

        while (header_q.size() != 0 || s_axis_tvalid || frame_info_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: mpeg_audio_header_decoder.f
rtl/core/mahd_pkg.sv
rtl/core/mahd_front.sv
rtl/core/mahd_queue.sv
rtl/core/mahd_back.sv
rtl/core/mpeg_audio_header_decoder.sv
tb/tb.sv
